/* rtl/fnc_pkg.sv */
// Package for the frequency to note classifier.
// Holds fixed-point constants, parameter defaults and the sequencer state type.
// No dependencies.
`default_nettype none

package fnc_pkg;

    localparam int FREQ_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF = 8;

    localparam int EXT_BITS = 12;
    localparam int A4_BITS = 17;
    localparam int PROD_BITS = 32;
    localparam int LO_BITS = 24;
    localparam int ROOT_FRAC_BITS = 12;
    localparam int ROOT_SHIFT = 16;
    localparam int REM_BITS = 11;
    localparam int QUO_BITS = 22;
    localparam int RECIP_BITS = 33;
    localparam int RECIP_SHIFT = 43;
    localparam int STEP_LIMIT = 32;

    localparam logic [A4_BITS-1:0] A4_MIN = 17'd102400;
    localparam logic [A4_BITS-1:0] A4_MAX = 17'd122880;
    localparam logic [A4_BITS-1:0] A4_RESET = 17'd112640;

    localparam int C4_NUM = 26163;
    localparam logic [REM_BITS-1:0] C4_DIV = 11'd1375;
    // Ceiling of 2^43 / 1375, exact for every dividend below 2^32.
    localparam logic [RECIP_BITS-1:0] C4_RECIP = 33'd6397158562;
    localparam logic [ROOT_FRAC_BITS-1:0] ROOT2_FRAC = 12'd3897;

    localparam logic [3:0] NOTE_LAST = 4'd11;
    localparam logic [4:0] OCT_C4 = 5'd4;

    typedef enum logic [3:0] {
        ST_PMUL,
        ST_QHI,
        ST_REM,
        ST_QLO,
        ST_IDLE,
        ST_OCT,
        ST_MLO,
        ST_MHI,
        ST_DEC,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* rtl/fnc_ifs.sv */
// Channel interfaces for the frequency to note classifier.
// Frequency input, tuning write and note result; depends on nothing else.
`default_nettype none

interface fnc_freq_if #(
    parameter int FREQ_BITS = 24
);
    logic                 valid;
    logic                 ready;
    logic [FREQ_BITS-1:0] frequency;

    modport source (output valid, output frequency, input ready);
    modport sink (input valid, input frequency, output ready);
endinterface

interface fnc_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] a4_tuning_hz;

    modport source (output valid, output a4_tuning_hz, input ready);
    modport sink (input valid, input a4_tuning_hz, output ready);
endinterface

interface fnc_note_if;
    logic              valid;
    logic              ready;
    logic              note_valid;
    logic [3:0]        note_index;
    logic signed [4:0] octave_number;

    modport source (output valid, output note_valid, output note_index,
                    output octave_number, input ready);
    modport sink (input valid, input note_valid, input note_index,
                  input octave_number, output ready);
endinterface

`default_nettype wire

/* rtl/frequency_to_note_classifier_core.sv */
// Top level of the frequency to note classifier: sequencer and shared datapath.
// Depends on fnc_pkg and the channel interfaces in fnc_ifs.sv.
//
// Channel   Direction  Payload                                     Handshake
// i_freq    in         frequency (Q.FRAC_BITS Hz)                  valid/ready
// i_cfg     in         a4_tuning_hz (Q9.8 Hz)                      valid/ready
// o_note    out        note_valid, note_index, octave_number       valid/ready
//
// After reset and after every tuning write the C4 reference is rebuilt through the
// states PMUL, QHI, REM and QLO by a shared reciprocal multiplier, during which no
// frequency is taken. An item then runs the octave loop, then semitone steps on the
// shared 24 x 12 semitone multiplier, then a nearest-note decision before the result.
// A zero frequency goes straight to the final state. The result waits in an output
// register, and a stalled output holds the sequencer in its final state until the
// register frees. A tuning write is taken only while no item is in progress.
`default_nettype none

module frequency_to_note_classifier_core #(
    parameter int FREQ_BITS = fnc_pkg::FREQ_BITS_DEF,
    parameter int FRAC_BITS = fnc_pkg::FRAC_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    fnc_freq_if.sink     i_freq,
    fnc_cfg_if.sink      i_cfg,
    fnc_note_if.source   o_note
);

    localparam int RW = fnc_pkg::QUO_BITS + FRAC_BITS - 1;
    localparam int FXW = FREQ_BITS + fnc_pkg::EXT_BITS + 1;
    localparam int W = ((FXW > RW) ? FXW : RW) + 1;
    localparam int SW = W + fnc_pkg::ROOT_FRAC_BITS;
    localparam int MW = fnc_pkg::LO_BITS + fnc_pkg::ROOT_FRAC_BITS;
    localparam int RPW = fnc_pkg::PROD_BITS + fnc_pkg::RECIP_BITS;
    localparam int CNT_W = $clog2(fnc_pkg::STEP_LIMIT + 1);

    fnc_pkg::t_state r_state, n_state;

    logic [fnc_pkg::A4_BITS-1:0]   r_a4;
    logic [fnc_pkg::PROD_BITS-1:0] r_x, n_x;
    logic [fnc_pkg::QUO_BITS-1:0]  r_q, n_q;
    logic [fnc_pkg::PROD_BITS-1:0] r_z, n_z;
    logic [RW-1:0]                 r_ref, n_ref;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [W-1:0]                  r_fx, n_fx;
    logic [W-1:0]                  r_c, n_c;
    logic [W-1:0]                  r_r, n_r;
    logic [MW-1:0]                 r_acc, n_acc;
    logic                          r_up, n_up;
    logic                          r_zero, n_zero;
    logic [3:0]                    r_note, n_note;
    logic [4:0]                    r_oct, n_oct;
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_note_valid, n_out_note_valid;
    logic [3:0]                    r_out_index, n_out_index;
    logic [4:0]                    r_out_oct, n_out_oct;

    logic [fnc_pkg::A4_BITS-1:0]    w_a4_sat;
    logic [fnc_pkg::PROD_BITS-1:0]  w_p;
    logic [fnc_pkg::PROD_BITS-1:0]  w_rec_op;
    logic [RPW-1:0]                 w_rec_prod;
    logic [fnc_pkg::QUO_BITS-1:0]   w_rec_q;
    logic [fnc_pkg::PROD_BITS-1:0]  w_rem;
    logic [fnc_pkg::LO_BITS-1:0]    w_mul_op;
    logic [MW-1:0]                  w_prod;
    logic [SW-1:0]                  w_sum;
    logic [W-1:0]                   w_semi;
    logic [W-1:0]                   w_fx_in;
    logic                           w_busy;
    logic                           w_cfg_take;

    always_comb begin
        priority if (r_a4 < fnc_pkg::A4_MIN) begin
            w_a4_sat = fnc_pkg::A4_MIN;
        end else if (r_a4 > fnc_pkg::A4_MAX) begin
            w_a4_sat = fnc_pkg::A4_MAX;
        end else begin
            w_a4_sat = r_a4;
        end
    end

    assign w_p = fnc_pkg::PROD_BITS'(w_a4_sat) * fnc_pkg::PROD_BITS'(fnc_pkg::C4_NUM);

    // The reference is floor(p * 2^(FRAC_BITS-1) / 1375), split into the quotient
    // of p and the quotient of the shifted remainder, both by reciprocal multiply.
    assign w_rec_op = (r_state == fnc_pkg::ST_QLO) ? r_z : r_x;
    assign w_rec_prod = RPW'(w_rec_op) * RPW'(fnc_pkg::C4_RECIP);
    assign w_rec_q = w_rec_prod[fnc_pkg::RECIP_SHIFT +: fnc_pkg::QUO_BITS];
    assign w_rem = r_x - fnc_pkg::PROD_BITS'(r_q) * fnc_pkg::PROD_BITS'(fnc_pkg::C4_DIV);

    assign w_mul_op = (r_state == fnc_pkg::ST_MHI) ?
                      fnc_pkg::LO_BITS'(r_c[W-1:fnc_pkg::LO_BITS]) :
                      r_c[fnc_pkg::LO_BITS-1:0];
    assign w_prod = MW'(w_mul_op) * MW'(fnc_pkg::ROOT2_FRAC);
    assign w_sum = SW'(r_acc) + (SW'(w_prod) << fnc_pkg::LO_BITS);
    assign w_semi = r_c + W'(w_sum >> fnc_pkg::ROOT_SHIFT);

    assign w_fx_in = W'(i_freq.frequency) << fnc_pkg::EXT_BITS;

    assign w_busy = (r_state == fnc_pkg::ST_OCT) || (r_state == fnc_pkg::ST_MLO) ||
                    (r_state == fnc_pkg::ST_MHI) || (r_state == fnc_pkg::ST_DEC) ||
                    (r_state == fnc_pkg::ST_DONE);

    assign i_freq.ready = (r_state == fnc_pkg::ST_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = !w_busy;
    assign w_cfg_take = i_cfg.valid && i_cfg.ready;

    assign o_note.valid = r_out_valid;
    assign o_note.note_valid = r_out_note_valid;
    assign o_note.note_index = r_out_index;
    assign o_note.octave_number = $signed(r_out_oct);

    always_comb begin
        n_state = r_state;
        n_x = r_x;
        n_q = r_q;
        n_z = r_z;
        n_ref = r_ref;
        n_cnt = r_cnt;
        n_fx = r_fx;
        n_c = r_c;
        n_r = r_r;
        n_acc = r_acc;
        n_up = r_up;
        n_zero = r_zero;
        n_note = r_note;
        n_oct = r_oct;
        n_out_valid = r_out_valid && !o_note.ready;
        n_out_note_valid = r_out_note_valid;
        n_out_index = r_out_index;
        n_out_oct = r_out_oct;

        unique case (r_state)
            fnc_pkg::ST_PMUL: begin
                n_x = w_p;
                n_state = fnc_pkg::ST_QHI;
            end
            fnc_pkg::ST_QHI: begin
                n_q = w_rec_q;
                n_state = fnc_pkg::ST_REM;
            end
            fnc_pkg::ST_REM: begin
                n_z = w_rem << (FRAC_BITS - 1);
                n_state = fnc_pkg::ST_QLO;
            end
            fnc_pkg::ST_QLO: begin
                n_ref = (RW'(r_q) << (FRAC_BITS - 1)) + RW'(w_rec_q);
                n_state = fnc_pkg::ST_IDLE;
            end
            fnc_pkg::ST_IDLE: begin
                if (i_freq.valid && i_freq.ready) begin
                    n_fx = w_fx_in;
                    n_c = W'(r_ref);
                    n_up = (w_fx_in >= W'(r_ref));
                    n_zero = (i_freq.frequency == '0);
                    n_note = '0;
                    n_oct = fnc_pkg::OCT_C4;
                    n_cnt = '0;
                    n_state = (i_freq.frequency == '0) ? fnc_pkg::ST_DONE : fnc_pkg::ST_OCT;
                end
            end
            fnc_pkg::ST_OCT: begin
                if (r_up) begin
                    if (r_fx >= (r_c << 1)) begin
                        n_c = r_c << 1;
                        n_oct = r_oct + 1'b1;
                    end else begin
                        n_state = fnc_pkg::ST_MLO;
                    end
                end else begin
                    if (r_fx < r_c) begin
                        n_c = r_c >> 1;
                        n_oct = r_oct - 1'b1;
                    end else begin
                        n_state = fnc_pkg::ST_MLO;
                    end
                end
            end
            fnc_pkg::ST_MLO: begin
                n_acc = w_prod;
                n_state = fnc_pkg::ST_MHI;
            end
            fnc_pkg::ST_MHI: begin
                n_r = w_semi;
                if (r_fx >= w_semi && r_cnt < CNT_W'(fnc_pkg::STEP_LIMIT)) begin
                    n_c = w_semi;
                    n_cnt = r_cnt + 1'b1;
                    if (r_note == fnc_pkg::NOTE_LAST) begin
                        n_note = '0;
                        n_oct = r_oct + 1'b1;
                    end else begin
                        n_note = r_note + 1'b1;
                    end
                    n_state = fnc_pkg::ST_MLO;
                end else begin
                    n_state = fnc_pkg::ST_DEC;
                end
            end
            fnc_pkg::ST_DEC: begin
                if (r_r >= r_fx && (r_fx - r_c) > (r_r - r_fx)) begin
                    if (r_note == fnc_pkg::NOTE_LAST) begin
                        n_note = '0;
                        n_oct = r_oct + 1'b1;
                    end else begin
                        n_note = r_note + 1'b1;
                    end
                end
                n_state = fnc_pkg::ST_DONE;
            end
            fnc_pkg::ST_DONE: begin
                if (!r_out_valid || o_note.ready) begin
                    n_out_valid = 1'b1;
                    n_out_note_valid = !r_zero;
                    n_out_index = r_zero ? 4'd0 : r_note;
                    n_out_oct = r_zero ? 5'd0 : r_oct;
                    n_state = fnc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fnc_pkg::ST_PMUL;
            end
        endcase

        if (w_cfg_take) begin
            n_state = fnc_pkg::ST_PMUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fnc_pkg::ST_PMUL;
            r_a4 <= fnc_pkg::A4_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (w_cfg_take) begin
                r_a4 <= i_cfg.a4_tuning_hz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_q <= n_q;
        r_z <= n_z;
        r_ref <= n_ref;
        r_cnt <= n_cnt;
        r_fx <= n_fx;
        r_c <= n_c;
        r_r <= n_r;
        r_acc <= n_acc;
        r_up <= n_up;
        r_zero <= n_zero;
        r_note <= n_note;
        r_oct <= n_oct;
        r_out_note_valid <= n_out_note_valid;
        r_out_index <= n_out_index;
        r_out_oct <= n_out_oct;
    end

    a_note_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_note.valid |-> o_note.note_index <= fnc_pkg::NOTE_LAST)
        else $error("note index out of range");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_note.valid && !o_note.note_valid) |->
        (o_note.note_index == 4'd0 && o_note.octave_number == 5'sd0))
        else $error("invalid result carries a nonzero note");

    a_start_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_freq.valid && i_freq.ready && i_freq.frequency != '0 && !i_cfg.valid) |=>
        (r_state == fnc_pkg::ST_OCT))
        else $error("accepted frequency did not start the octave search");

    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |=> (r_state == fnc_pkg::ST_PMUL && !i_freq.ready))
        else $error("tuning write did not rebuild the reference");

endmodule

`default_nettype wire
